@@ sv/bsa_pkg.sv @@
// shared types and constants of the bitmap section allocator
`default_nettype none

package bsa_pkg;

    localparam int POS_W          = 21;
    localparam int MAPB_W         = 10;
    localparam int SECTION_BYTES  = 512;
    localparam int SECTION_SHIFT  = $clog2(SECTION_BYTES);
    localparam int FREE_IDX_LSB   = SECTION_SHIFT + 3;
    localparam int FREE_IDX_W     = POS_W - FREE_IDX_LSB;

    localparam logic [7:0]        FULL_BYTE       = 8'hFF;
    localparam logic [7:0]        TOP_BIT         = 8'h80;
    localparam logic [MAPB_W-1:0] MAP_BYTES_RESET = 10'd512;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] position_out;
        logic             found;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_MISS
    } t_state;

    // offset from the msb of the first clear bit; byte must not be full
    function automatic logic [2:0] first_clear_off(input logic [7:0] b);
        logic [2:0] off;
        off = 3'd7;
        for (int k = 7; k >= 0; k--) begin
            if (!b[7-k]) begin
                off = 3'(k);
            end
        end
        return off;
    endfunction

endpackage

`default_nettype wire

@@ sv/bitmap_section_allocator_top.sv @@
// top level of the bitmap section allocator: free map memory and request sequencer
// The free map sits in one synchronous byte memory of MAP_BYTES entries, one bit per
// section, msb first. After reset a clearing pass writes every entry (entry 0 gets
// section 0 marked used); no item is accepted meanwhile, though configuration writes
// are. An allocate item reads the map one byte per cycle from byte 0 until it meets a
// byte that is not full, then sets that byte's first clear bit in the same cycle it
// writes the result; it reads at most min(map_bytes, MAP_BYTES) bytes, so the memory
// read port sets the rate. A free item is one read and one write. Items that need no
// map access (empty scan range, free beyond the map) pass through a miss state. The
// result sits in an output register, so a new item is taken while it waits; the final
// write of the next item waits until that register is free. map_bytes must be written
// through the config channel only while the block is idle; the block does not enforce
// this itself.
`default_nettype none

module bitmap_section_allocator_top #(
    parameter int MAP_BYTES = 512
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // request channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire bsa_pkg::t_in_item           i_data,
    // result channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output bsa_pkg::t_out_item               o_data,
    // map_bytes register write
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [bsa_pkg::MAPB_W-1:0]        i_cfg_data
);

    // address and scan limit widths
    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int LW = $clog2(MAP_BYTES + 1);
    localparam int CW = (LW > bsa_pkg::MAPB_W) ? LW : bsa_pkg::MAPB_W;
    // width of section number times section size before wrapping to the port width
    localparam int SW = AW + 3 + bsa_pkg::SECTION_SHIFT;
    localparam int PX = (SW > bsa_pkg::POS_W) ? SW : bsa_pkg::POS_W;

    // free map storage
    logic [7:0] r_mem [MAP_BYTES];
    logic [7:0] r_rd_data;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // control and payload registers
    bsa_pkg::t_state           r_state,     n_state;
    logic [AW-1:0]             r_clr_addr,  n_clr_addr;
    logic [AW-1:0]             r_addr,      n_addr;
    logic [CW-1:0]             r_limit,     n_limit;
    logic [7:0]                r_mask,      n_mask;
    logic [bsa_pkg::MAPB_W-1:0] r_map_bytes;
    logic                      r_out_valid, n_out_valid;
    bsa_pkg::t_out_item        r_out,       n_out;

    // derived values
    logic                              out_free;
    logic [CW-1:0]                     cfg_limit;
    logic [bsa_pkg::FREE_IDX_W-1:0]    free_idx;
    logic [2:0]                        free_bit;
    logic                              free_in_map;
    logic [2:0]                        clr_off;
    logic [PX-1:0]                     alloc_pos;
    logic [CW-1:0]                     next_count;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_stall     = (r_state != bsa_pkg::ST_IDLE);

    // result register may be loaded this cycle
    assign out_free = !r_out_valid || !i_stall;

    // bytes to scan: min(map_bytes, MAP_BYTES)
    assign cfg_limit = (CW'(r_map_bytes) < CW'(MAP_BYTES)) ? CW'(r_map_bytes)
                                                           : CW'(MAP_BYTES);

    // section byte index and bit of a free request
    assign free_idx    = i_data.position[bsa_pkg::POS_W-1:bsa_pkg::FREE_IDX_LSB];
    assign free_bit    = i_data.position[bsa_pkg::FREE_IDX_LSB-1:bsa_pkg::SECTION_SHIFT];
    assign free_in_map = (32'(free_idx) < 32'(MAP_BYTES));

    // allocation result for the byte under scan
    assign clr_off    = bsa_pkg::first_clear_off(r_rd_data);
    assign alloc_pos  = PX'({r_addr, clr_off}) << bsa_pkg::SECTION_SHIFT;
    assign next_count = CW'(r_addr) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsa_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_map_bytes <= bsa_pkg::MAP_BYTES_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_map_bytes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_limit <= n_limit;
        r_mask  <= n_mask;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_addr      = r_addr;
        n_limit     = r_limit;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = r_rd_data;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;

        case (r_state)
            bsa_pkg::ST_CLEAR: begin
                // one entry per cycle, section 0 starts out used
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = (r_clr_addr == '0) ? bsa_pkg::TOP_BIT : 8'h00;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAP_BYTES - 1)) begin
                    n_state = bsa_pkg::ST_IDLE;
                end
            end
            bsa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_data.action == bsa_pkg::ACT_FREE) begin
                        if (free_in_map) begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(free_idx);
                            n_addr    = AW'(free_idx);
                            n_mask    = bsa_pkg::TOP_BIT >> free_bit;
                            n_state   = bsa_pkg::ST_FREE;
                        end else begin
                            n_state = bsa_pkg::ST_MISS;
                        end
                    end else if (cfg_limit == '0) begin
                        n_state = bsa_pkg::ST_MISS;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_addr    = '0;
                        n_limit   = cfg_limit;
                        n_state   = bsa_pkg::ST_SCAN;
                    end
                end
            end
            bsa_pkg::ST_SCAN: begin
                if (r_rd_data != bsa_pkg::FULL_BYTE) begin
                    // claim the first clear bit, held until the result register frees
                    if (out_free) begin
                        mem_we             = 1'b1;
                        mem_waddr          = r_addr;
                        mem_wdata          = r_rd_data | (bsa_pkg::TOP_BIT >> clr_off);
                        n_out.position_out = alloc_pos[bsa_pkg::POS_W-1:0];
                        n_out.found        = 1'b1;
                        n_out_valid        = 1'b1;
                        n_state            = bsa_pkg::ST_IDLE;
                    end
                end else if (next_count == r_limit) begin
                    // map full within the scan range
                    if (out_free) begin
                        n_out.position_out = '0;
                        n_out.found        = 1'b0;
                        n_out_valid        = 1'b1;
                        n_state            = bsa_pkg::ST_IDLE;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                end
            end
            bsa_pkg::ST_FREE: begin
                if (out_free) begin
                    mem_we             = 1'b1;
                    mem_waddr          = r_addr;
                    mem_wdata          = r_rd_data & ~r_mask;
                    n_out.position_out = '0;
                    n_out.found        = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = bsa_pkg::ST_IDLE;
                end
            end
            bsa_pkg::ST_MISS: begin
                // empty scan range or free beyond the map
                if (out_free) begin
                    n_out.position_out = '0;
                    n_out.found        = 1'b0;
                    n_out_valid        = 1'b1;
                    n_state            = bsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bsa_checker.sv @@
// port level checks of the bitmap section allocator and their bind
`default_nettype none

module bsa_checker (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_valid,
    input wire                     o_stall,
    input wire                     o_valid,
    input wire                     i_stall,
    input wire bsa_pkg::t_out_item o_data
);

    // a stalled result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result withdrawn while stalled");

    // a taken request leaves the block busy afterwards
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without a busy cycle");

    // a failed result carries position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.found |-> o_data.position_out == '0)
        else $error("failed result with nonzero position");

    // every position is section aligned
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.position_out[bsa_pkg::SECTION_SHIFT-1:0] == '0)
        else $error("position not section aligned");

endmodule

bind bitmap_section_allocator_top bsa_checker u_bsa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
